// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the rasterizer top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/tcgr_pkg.sv =====
// Constants, types and helper functions of the text glyph rasterizer.
package tcgr_pkg;

  // Screen and font geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int GLYPH_PIXELS  = 8;
  localparam int GLYPH_ROWS    = 8;
  localparam int FONT_SLOTS    = 128;
  localparam int FONT_DEPTH    = 1024;
  localparam int FONT_AW       = 10;
  localparam int MAX_ROWS      = 32;

  // Vertical scale limit: a cell never exceeds MAX_ROWS rows
  localparam int SCALE_RAW = MAX_ROWS / GLYPH_ROWS;
  localparam int SCALE_CAP = (SCALE_RAW > 4) ? 4 : ((SCALE_RAW < 1) ? 1 : SCALE_RAW);

  // Internal widths
  localparam int SCALE_W = 3;
  localparam int REP_W   = 2;
  localparam int ROW_W   = $clog2(MAX_ROWS + 1);
  localparam int GROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int CX_RAW  = $clog2(SCREEN_WIDTH + 1);
  localparam int CX_W    = (CX_RAW > 9) ? CX_RAW : 9;
  localparam int CY_W    = $clog2(SCREEN_HEIGHT + 1);
  localparam int SUM_W   = 14;
  localparam int PIX_W   = 16;

  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_CHAR  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_FORE  = 3'd0,
    REG_BACK  = 3'd1,
    REG_SCALE = 3'd2,
    REG_LOW   = 3'd3,
    REG_HIGH  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Side data of one pixel row on its way through the font read
  typedef struct packed {
    logic [8:0] x;
    logic [7:0] y;
    logic       last;
    logic       blank;
  } row_meta_t;

  // Register value to effective vertical scale: zero acts as one, clamp at cap
  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    r = s;
    if (s == '0) r = SCALE_W'(1);
    if (s > SCALE_W'(SCALE_CAP)) r = SCALE_W'(SCALE_CAP);
    return r;
  endfunction

  // Row position from a sum, saturating at the screen height
  function automatic logic [CY_W-1:0] sat_y(input logic [SUM_W-1:0] v);
    logic [CY_W-1:0] r;
    if (v > SUM_W'(SCREEN_HEIGHT)) r = CY_W'(SCREEN_HEIGHT);
    else r = v[CY_W-1:0];
    return r;
  endfunction

  // Font row address of a glyph row, wrapping over the font memory
  function automatic logic [FONT_AW-1:0] font_addr(input logic [7:0] slot,
                                                   input logic [GROW_W-1:0] g);
    logic [31:0] a;
    a = 32'(slot) * 32'(GLYPH_ROWS) + 32'(g);
    return a[FONT_AW-1:0];
  endfunction

  // Expand eight glyph bits to colours, bit 0 leftmost in the low word
  function automatic logic [8*PIX_W-1:0] expand(input logic [7:0] bits,
                                                input logic [PIX_W-1:0] fore,
                                                input logic [PIX_W-1:0] back);
    logic [8*PIX_W-1:0] r;
    for (int c = 0; c < 8; c++) begin
      r[c*PIX_W +: PIX_W] = bits[c] ? fore : back;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/text_cursor_glyph_rasterizer_top.sv =====
// Text glyph rasterizer: font memory, cursor control and pixel row sequencer.
// Load, start and non-rendering character words do not enter the run state.
// A rendered character stalls the input while its pixel rows are read:
// one font memory read per pixel row on the single read port sets the pace.
// Each pixel row goes from the font read stage to the output register.
// Reset zeroes the cursor, sets the stop flag, idles the sequencer and loads
// register defaults; the font memory has no reset and holds garbage until loaded.
`include "assert_macros.svh"

module text_cursor_glyph_rasterizer_top
  import tcgr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  font_index_i,
  input  logic [7:0]  font_byte_i,
  input  logic [8:0]  origin_x_i,
  input  logic [7:0]  origin_y_i,
  input  logic [7:0]  char_code_i,
  // output word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  cell_x_o,
  output logic [7:0]  pixel_y_o,
  output logic [63:0] pixels_left_o,
  output logic [63:0] pixels_right_o,
  output logic        last_row_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  logic [PIX_W-1:0]   fore_q, back_q;
  logic [SCALE_W-1:0] scale_cfg_q;
  logic [7:0]         low_q, high_q;

  // Cursor state
  logic [CX_W-1:0] cursor_x_q, margin_q;
  logic [CY_W-1:0] cursor_y_q;
  logic            stopped_q;

  // Sequencer
  state_e             state_q, state_d;
  logic [CX_W-1:0]    run_x_q;
  logic [CY_W-1:0]    run_y_q;
  logic [7:0]         slot_q;
  logic               blank_q;
  logic [SCALE_W-1:0] scale_q;
  logic [ROW_W-1:0]   rh_q, row_q;
  logic [GROW_W-1:0]  g_q;
  logic [REP_W-1:0]   rep_q;

  // Font memory and read stage
  logic [7:0]         font_mem [FONT_DEPTH];
  logic [7:0]         rd_data_q;
  logic               b_valid_q;
  row_meta_t          b_meta_q, b_meta_d;

  // Output register
  logic               out_valid_q;
  row_meta_t          out_meta_q;
  logic [8*PIX_W-1:0] out_pix_q;

  logic in_acc, mem_we, rd_en, b_adv, run_go, row_last;
  logic [FONT_AW-1:0] rd_addr;

  // Character decode
  logic [SCALE_W-1:0] scale_w;
  logic [ROW_W-1:0]   rh_w;
  logic               wrap, nofit, in_range, slot_ok;
  logic [CX_W-1:0]    cx_w;
  logic [CY_W-1:0]    cy_w, y_adv;
  logic [7:0]         code_m, slot_w;
  action_e            act;

  assign act         = action_e'(action_i);
  assign in_stall_o  = (state_q == ST_RUN);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign mem_we      = in_acc && (act == ACT_LOAD);
  assign cfg_ready_o = 1'b1;

  // Wrap, stop and slot selection for a character word
  always_comb begin
    scale_w  = eff_scale(scale_cfg_q);
    rh_w     = ROW_W'(scale_w) * ROW_W'(GLYPH_ROWS);
    y_adv    = sat_y(SUM_W'(cursor_y_q) + SUM_W'(rh_w));
    wrap     = (SUM_W'(cursor_x_q) + SUM_W'(GLYPH_PIXELS)) > SUM_W'(SCREEN_WIDTH);
    cx_w     = wrap ? '0 : cursor_x_q;
    cy_w     = wrap ? y_adv : cursor_y_q;
    nofit    = (SUM_W'(cy_w) + SUM_W'(rh_w)) > SUM_W'(SCREEN_HEIGHT);
    in_range = (char_code_i >= low_q) && (char_code_i <= high_q);
    code_m   = in_range ? char_code_i : SPACE_CODE;
    slot_w   = code_m - low_q;
    slot_ok  = {1'b0, slot_w} < 9'(FONT_SLOTS);
  end

  assign run_go = in_acc && (act == ACT_CHAR) && !stopped_q &&
                  (char_code_i != NEWLINE_CODE) && !nofit;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q      <= 16'hFFFF;
      back_q      <= '0;
      scale_cfg_q <= SCALE_W'(2);
      low_q       <= 8'd32;
      high_q      <= 8'd127;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FORE:  fore_q      <= cfg_data_i;
        REG_BACK:  back_q      <= cfg_data_i;
        REG_SCALE: scale_cfg_q <= cfg_data_i[SCALE_W-1:0];
        REG_LOW:   low_q       <= cfg_data_i[7:0];
        REG_HIGH:  high_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Cursor update on start and character words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      margin_q   <= '0;
      stopped_q  <= 1'b1;
    end else if (in_acc) begin
      case (act)
        ACT_START: begin
          cursor_x_q <= CX_W'(origin_x_i);
          margin_q   <= CX_W'(origin_x_i);
          cursor_y_q <= sat_y(SUM_W'(origin_y_i));
          stopped_q  <= 1'b0;
        end
        ACT_CHAR: begin
          if (!stopped_q) begin
            if (char_code_i == NEWLINE_CODE) begin
              cursor_x_q <= margin_q;
              cursor_y_q <= y_adv;
            end else begin
              cursor_y_q <= cy_w;
              if (nofit) begin
                cursor_x_q <= cx_w;
                stopped_q  <= 1'b1;
              end else begin
                cursor_x_q <= cx_w + CX_W'(GLYPH_PIXELS);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Row issue: one font read per pixel row when the read stage has room
  assign b_adv    = b_valid_q && (!out_valid_q || !out_stall_i);
  assign rd_en    = (state_q == ST_RUN) && (!b_valid_q || b_adv);
  assign rd_addr  = font_addr(slot_q, g_q);
  assign row_last = (row_q == rh_q - ROW_W'(1));

  always_comb begin
    b_meta_d.x     = run_x_q[8:0];
    b_meta_d.y     = 8'(SUM_W'(run_y_q) + SUM_W'(row_q));
    b_meta_d.last  = row_last;
    b_meta_d.blank = blank_q;
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (run_go) state_d = ST_RUN;
      ST_RUN:  if (rd_en && row_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Per-character counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      g_q   <= '0;
      rep_q <= '0;
    end else if (run_go) begin
      row_q <= '0;
      g_q   <= '0;
      rep_q <= '0;
    end else if (rd_en) begin
      row_q <= row_q + ROW_W'(1);
      if (SCALE_W'(rep_q) + SCALE_W'(1) == scale_q) begin
        rep_q <= '0;
        g_q   <= g_q + GROW_W'(1);
      end else begin
        rep_q <= rep_q + REP_W'(1);
      end
    end
  end

  // Character payload, captured at accept
  always_ff @(posedge clk_i) begin
    if (run_go) begin
      run_x_q <= cx_w;
      run_y_q <= cy_w;
      slot_q  <= slot_w;
      blank_q <= !slot_ok;
      scale_q <= scale_w;
      rh_q    <= rh_w;
    end
  end

  // Font memory: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) font_mem[font_index_i] <= font_byte_i;
    if (rd_en) rd_data_q <= font_mem[rd_addr];
  end

  // Read stage occupancy and side data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_valid_q <= 1'b0;
    else if (rd_en) b_valid_q <= 1'b1;
    else if (b_adv) b_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) b_meta_q <= b_meta_d;
  end

  // Output register: colour expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (b_adv) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_meta_q <= b_meta_q;
      out_pix_q  <= expand(b_meta_q.blank ? 8'h00 : rd_data_q, fore_q, back_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_x_o       = out_meta_q.x;
  assign pixel_y_o      = out_meta_q.y;
  assign last_row_o     = out_meta_q.last;
  assign pixels_left_o  = out_pix_q[4*PIX_W-1:0];
  assign pixels_right_o = out_pix_q[8*PIX_W-1:4*PIX_W];

  // Checks
  `ASSERT_CLK(a_row_in_cell, (state_q == ST_RUN) |-> (row_q < rh_q))
  `ASSERT_CLK(a_rep_below_scale, (state_q == ST_RUN) |-> (SCALE_W'(rep_q) < scale_q))
  `ASSERT_NEVER(a_cursor_y_range, cursor_y_q > CY_W'(SCREEN_HEIGHT))
  `ASSERT_CLK(a_read_stage_hold, (b_valid_q && !b_adv) |=> (b_valid_q && $stable(b_meta_q)))

endmodule
